FILE: rtl/fcp_pkg.sv
// Shared types, codes and constants for the framed command parser.
package fcp_pkg;

    // Default payload buffer depth
    localparam int PAYLOAD_MAX_DEF = 32;

    // Configuration register file
    localparam int          CFG_IDX_W      = 8;
    localparam logic [7:0]  START_BYTE_RST = 8'd2;
    localparam logic [7:0]  END_BYTE_RST   = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE = 8'd0,
        CFG_END_BYTE   = 8'd1
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_END_BYTE = 2'd2,
        ST_LENGTH   = 2'd3
    } status_t;

    // Receive and readout phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN     = 3'd2,
        PH_DATA    = 3'd3,
        PH_CHECK   = 3'd4,
        PH_END     = 3'd5,
        PH_RD_ADDR = 3'd6,
        PH_RD_DATA = 3'd7
    } phase_t;

    // Kind of result word loaded into the output register
    typedef enum logic [2:0] {
        EM_LEN_ERR = 3'd0,
        EM_CHK_ERR = 3'd1,
        EM_END_ERR = 3'd2,
        EM_EMPTY   = 3'd3,
        EM_PAYLOAD = 3'd4
    } emit_t;

    // Channel words
    typedef struct packed {
        logic [7:0] in_byte;
    } in_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } cfg_word_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] command;
        logic [5:0] length;
        logic       has_payload;
        logic [7:0] payload_byte;
        logic [4:0] byte_index;
        logic       last;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic  cap_cmd;
        logic  cap_len;
        logic  store_data;
        logic  emit;
        emit_t emit_kind;
        logic  rd_start;
        logic  rd_issue;
        logic  rd_advance;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_start;
        logic len_too_large;
        logic byte_zero;
        logic len_zero;
        logic fill_done;
        logic check_ok;
        logic end_ok;
        logic rd_last;
        logic slot_free;
    } dp_stat_t;

endpackage

FILE: rtl/fcp_stream_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
interface fcp_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/fcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/fcp_ctrl.sv
// Frame parser controller: receive phases and payload readout sequencing.
module fcp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_ready,
    input  fcp_pkg::dp_stat_t stat,
    output fcp_pkg::ctl_cmd_t cmd
);
    fcp_pkg::phase_t phase_reg;
    fcp_pkg::phase_t phase_next;
    logic            receiving;
    logic            fire;

    // Bytes are taken in every receive phase once the output slot can take a result
    assign receiving = (phase_reg != fcp_pkg::PH_RD_ADDR) && (phase_reg != fcp_pkg::PH_RD_DATA);
    assign rx_ready  = receiving && stat.slot_free;
    assign fire      = rx_valid && rx_ready;

    // Phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fcp_pkg::PH_HUNT;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            fcp_pkg::PH_HUNT:
            begin
                if (fire && stat.is_start)
                begin
                    phase_next = fcp_pkg::PH_CMD;
                end
            end
            fcp_pkg::PH_CMD:
            begin
                if (fire)
                begin
                    phase_next = fcp_pkg::PH_LEN;
                end
            end
            fcp_pkg::PH_LEN:
            begin
                if (fire)
                begin
                    if (stat.len_too_large)
                    begin
                        phase_next = fcp_pkg::PH_HUNT;
                    end
                    else if (stat.byte_zero)
                    begin
                        phase_next = fcp_pkg::PH_CHECK;
                    end
                    else
                    begin
                        phase_next = fcp_pkg::PH_DATA;
                    end
                end
            end
            fcp_pkg::PH_DATA:
            begin
                if (fire && stat.fill_done)
                begin
                    phase_next = fcp_pkg::PH_CHECK;
                end
            end
            fcp_pkg::PH_CHECK:
            begin
                if (fire)
                begin
                    phase_next = stat.check_ok ? fcp_pkg::PH_END : fcp_pkg::PH_HUNT;
                end
            end
            fcp_pkg::PH_END:
            begin
                if (fire)
                begin
                    if (stat.end_ok && !stat.len_zero)
                    begin
                        phase_next = fcp_pkg::PH_RD_ADDR;
                    end
                    else
                    begin
                        phase_next = fcp_pkg::PH_HUNT;
                    end
                end
            end
            fcp_pkg::PH_RD_ADDR:
            begin
                phase_next = fcp_pkg::PH_RD_DATA;
            end
            fcp_pkg::PH_RD_DATA:
            begin
                if (stat.slot_free)
                begin
                    phase_next = stat.rd_last ? fcp_pkg::PH_HUNT : fcp_pkg::PH_RD_ADDR;
                end
            end
            default:
            begin
                phase_next = fcp_pkg::PH_HUNT;
            end
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.emit_kind = fcp_pkg::EM_EMPTY;
        unique case (phase_reg)
            fcp_pkg::PH_HUNT:
            begin
            end
            fcp_pkg::PH_CMD:
            begin
                cmd.cap_cmd = fire;
            end
            fcp_pkg::PH_LEN:
            begin
                cmd.cap_len   = fire;
                cmd.emit      = fire && stat.len_too_large;
                cmd.emit_kind = fcp_pkg::EM_LEN_ERR;
            end
            fcp_pkg::PH_DATA:
            begin
                cmd.store_data = fire;
            end
            fcp_pkg::PH_CHECK:
            begin
                cmd.emit      = fire && !stat.check_ok;
                cmd.emit_kind = fcp_pkg::EM_CHK_ERR;
            end
            fcp_pkg::PH_END:
            begin
                cmd.emit      = fire && (!stat.end_ok || stat.len_zero);
                cmd.emit_kind = stat.end_ok ? fcp_pkg::EM_EMPTY : fcp_pkg::EM_END_ERR;
                cmd.rd_start  = fire && stat.end_ok && !stat.len_zero;
            end
            fcp_pkg::PH_RD_ADDR:
            begin
                cmd.rd_issue = 1'b1;
            end
            fcp_pkg::PH_RD_DATA:
            begin
                cmd.emit       = stat.slot_free;
                cmd.emit_kind  = fcp_pkg::EM_PAYLOAD;
                cmd.rd_advance = stat.slot_free;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // No byte is taken while a frame is being read out
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fcp_pkg::PH_RD_ADDR || phase_reg == fcp_pkg::PH_RD_DATA) |-> !rx_ready)
        else $error("byte accepted during readout");

    // Every readout data step follows an address step
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fcp_pkg::PH_RD_DATA && !$past(phase_reg == fcp_pkg::PH_RD_DATA))
        |-> $past(phase_reg == fcp_pkg::PH_RD_ADDR))
        else $error("readout data step without address step");
`endif
endmodule

FILE: rtl/fcp_datapath.sv
// Frame parser datapath: config registers, frame fields, checksum, payload RAM, result register.
module fcp_datapath #(
    parameter int PAYLOAD_MAX = fcp_pkg::PAYLOAD_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  fcp_pkg::cfg_word_t cfg_word,
    input  fcp_pkg::in_word_t  rx_word,
    input  fcp_pkg::ctl_cmd_t  cmd,
    output fcp_pkg::dp_stat_t  stat,
    output logic               res_valid,
    input  logic               res_ready,
    output fcp_pkg::result_t   res_word
);
    localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
    localparam int AW    = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    logic [7:0]       start_byte_reg;
    logic [7:0]       end_byte_reg;
    logic [7:0]       held_command_reg;
    logic [CNT_W-1:0] held_length_reg;
    logic [CNT_W-1:0] fill_count_reg;
    logic [7:0]       check_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic             res_valid_reg;
    fcp_pkg::result_t res_reg;
    fcp_pkg::result_t res_next;
    logic [7:0]       b;
    logic [7:0]       rd_data;
    logic [CNT_W:0]   fill_plus;
    logic [5:0]       sat_len;

    assign b = rx_word.in_byte;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= fcp_pkg::START_BYTE_RST;
            end_byte_reg   <= fcp_pkg::END_BYTE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_word.index)
                fcp_pkg::CFG_START_BYTE: start_byte_reg <= cfg_word.data;
                fcp_pkg::CFG_END_BYTE:   end_byte_reg   <= cfg_word.data;
                default:
                begin
                end
            endcase
        end
    end

    // Frame fields, fill count and running XOR
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_command_reg <= '0;
            held_length_reg  <= '0;
            fill_count_reg   <= '0;
            check_reg        <= '0;
        end
        else
        begin
            if (cmd.cap_cmd)
            begin
                held_command_reg <= b;
            end
            if (cmd.cap_len)
            begin
                fill_count_reg <= '0;
                if (stat.len_too_large)
                begin
                    held_length_reg <= '0;
                    check_reg       <= '0;
                end
                else
                begin
                    held_length_reg <= CNT_W'(b);
                    check_reg       <= start_byte_reg ^ held_command_reg ^ b;
                end
            end
            if (cmd.store_data)
            begin
                check_reg      <= check_reg ^ b;
                fill_count_reg <= fill_plus[CNT_W-1:0];
            end
        end
    end

    // Readout index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.rd_start)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.rd_advance)
        begin
            rd_idx_reg <= rd_idx_reg + AW'(1);
        end
    end

    // Payload buffer
    fcp_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store_data),
        .waddr (fill_count_reg[AW-1:0]),
        .wdata (b),
        .re    (cmd.rd_issue),
        .raddr (rd_idx_reg),
        .rdata (rd_data)
    );

    // Status towards the controller
    assign fill_plus = {1'b0, fill_count_reg} + (CNT_W + 1)'(1);
    always_comb
    begin
        stat.is_start      = (b == start_byte_reg);
        stat.len_too_large = (b > 8'(PAYLOAD_MAX));
        // byte test for the length phase, held length for the end phase
        stat.byte_zero     = (b == 8'd0);
        stat.len_zero      = (held_length_reg == '0);
        stat.fill_done     = (fill_plus >= {1'b0, held_length_reg});
        stat.check_ok      = (b == check_reg);
        stat.end_ok        = (b == end_byte_reg);
        stat.rd_last       = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == held_length_reg);
        stat.slot_free     = !res_valid_reg || res_ready;
    end

    // Result word selection
    assign sat_len = (b > 8'd63) ? 6'd63 : b[5:0];
    always_comb
    begin
        res_next              = '0;
        res_next.command      = held_command_reg;
        res_next.length       = 6'(held_length_reg);
        res_next.last         = 1'b1;
        case (cmd.emit_kind)
            fcp_pkg::EM_LEN_ERR:
            begin
                res_next.status = fcp_pkg::ST_LENGTH;
                res_next.length = sat_len;
            end
            fcp_pkg::EM_CHK_ERR: res_next.status = fcp_pkg::ST_CHECKSUM;
            fcp_pkg::EM_END_ERR: res_next.status = fcp_pkg::ST_END_BYTE;
            fcp_pkg::EM_PAYLOAD:
            begin
                res_next.status       = fcp_pkg::ST_OK;
                res_next.has_payload  = 1'b1;
                res_next.payload_byte = rd_data;
                res_next.byte_index   = 5'(rd_idx_reg);
                res_next.last         = stat.rd_last;
            end
            default:
            begin
                res_next.status = fcp_pkg::ST_OK;
                res_next.length = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

`ifndef SYNTHESIS
    // A result is only loaded when the slot is free or being emptied
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!res_valid_reg || res_ready))
        else $error("result word overwritten");

    // Payload writes stay inside the buffer and the announced length
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_data |-> (fill_count_reg < held_length_reg))
        else $error("payload write beyond frame length");

    // Readout never runs past the held length
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_advance |-> (CNT_W'(rd_idx_reg) < held_length_reg))
        else $error("readout index beyond frame length");
`endif
endmodule

FILE: rtl/framed_command_parser.sv
// Top level of the framed command parser: controller, datapath and channel ports.
//
// Receives bytes of frames laid out as start, command, length, payload, XOR
// checksum, end. While receiving, one byte is taken per cycle as long as the
// single-word output register is empty or being taken; any byte waits while
// that register is full and not being taken. After the end byte of a good
// frame with payload, the buffer is read out byte by byte: a registered RAM
// read, then a load of the output register, which waits under output
// back-pressure. No byte is taken until the last payload word is in the
// output register. A frame of length L thus spans L + 5 bytes.
// Configuration writes are always taken. The payload buffer is not cleared
// after reset.
module framed_command_parser #(
    parameter int PAYLOAD_MAX = fcp_pkg::PAYLOAD_MAX_DEF
) (
    input logic         clk,
    input logic         rst_n,
    fcp_stream_if.sink   rx,
    fcp_stream_if.source result,
    fcp_stream_if.sink   cfg
);
    fcp_pkg::ctl_cmd_t ctl_cmd;
    fcp_pkg::dp_stat_t dp_stat;
    logic              rx_ready;

    // Register writes never stall
    assign cfg.ready = 1'b1;
    assign rx.ready  = rx_ready;

    // Controller
    fcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx_ready),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    // Datapath
    fcp_datapath #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_word  (cfg.payload),
        .rx_word   (rx.payload),
        .cmd       (ctl_cmd),
        .stat      (dp_stat),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res_word  (result.payload)
    );

`ifndef SYNTHESIS
    // An accepted byte and a readout command never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx_ready) |-> !(ctl_cmd.rd_issue || ctl_cmd.rd_advance))
        else $error("byte accepted while reading out");
`endif
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the framed command parser: directed frames, then random traffic.
module testbench;

    localparam int PAYLOAD_MAX  = fcp_pkg::PAYLOAD_MAX_DEF;
    localparam int SETTLE       = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 500000;
    localparam int RANDOM_BYTES = 300;

    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_END_BYTE
    } frame_flaw_t;

    logic clk;
    logic rst_n;

    fcp_stream_if #(.payload_t(fcp_pkg::in_word_t))  rx_ch ();
    fcp_stream_if #(.payload_t(fcp_pkg::result_t))   res_ch ();
    fcp_stream_if #(.payload_t(fcp_pkg::cfg_word_t)) cfg_ch ();

    framed_command_parser #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Parser copy: configuration and frame state
    logic [7:0]       cur_start;
    logic [7:0]       cur_end;
    fcp_pkg::phase_t  rx_phase;
    logic [7:0]       frame_cmd;
    logic [5:0]       frame_len;
    int               fill_count;
    logic [7:0]       frame_xor;
    logic [7:0]       frame_buf [PAYLOAD_MAX];

    fcp_pkg::result_t pending_results [$];

    int  bytes_sent;
    int  frames_sent;
    int  results_checked;
    int  mismatch_count;
    int  cycle_count;
    bit  tx_steady;
    bit  rx_steady;
    bit  backpressure_req;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("framed_command_parser: mismatch");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic fcp_pkg::result_t make_result(fcp_pkg::status_t st, logic [5:0] len,
                                                     logic has, logic [7:0] pbyte,
                                                     logic [4:0] idx, logic last);
        fcp_pkg::result_t r;
        r.status       = st;
        r.command      = frame_cmd;
        r.length       = len;
        r.has_payload  = has;
        r.payload_byte = pbyte;
        r.byte_index   = idx;
        r.last         = last;
        return r;
    endfunction

    // Advance the parser copy by one received byte and queue the words it produces
    task automatic parse_byte(input logic [7:0] b);
        case (rx_phase)
            fcp_pkg::PH_HUNT:
            begin
                if (b == cur_start)
                    rx_phase = fcp_pkg::PH_CMD;
            end
            fcp_pkg::PH_CMD:
            begin
                frame_cmd = b;
                rx_phase  = fcp_pkg::PH_LEN;
            end
            fcp_pkg::PH_LEN:
            begin
                fill_count = 0;
                if (b > PAYLOAD_MAX)
                begin
                    frame_len = '0;
                    frame_xor = '0;
                    pending_results.push_back(make_result(fcp_pkg::ST_LENGTH,
                        (b > 8'd63) ? 6'd63 : b[5:0], 1'b0, 8'd0, 5'd0, 1'b1));
                    rx_phase = fcp_pkg::PH_HUNT;
                end
                else
                begin
                    frame_len = b[5:0];
                    frame_xor = cur_start ^ frame_cmd ^ b;
                    rx_phase  = (b != 0) ? fcp_pkg::PH_DATA : fcp_pkg::PH_CHECK;
                end
            end
            fcp_pkg::PH_DATA:
            begin
                frame_buf[fill_count] = b;
                frame_xor  = frame_xor ^ b;
                fill_count = fill_count + 1;
                if (fill_count >= frame_len)
                    rx_phase = fcp_pkg::PH_CHECK;
            end
            fcp_pkg::PH_CHECK:
            begin
                if (b != frame_xor)
                begin
                    pending_results.push_back(make_result(fcp_pkg::ST_CHECKSUM, frame_len,
                        1'b0, 8'd0, 5'd0, 1'b1));
                    rx_phase = fcp_pkg::PH_HUNT;
                end
                else
                    rx_phase = fcp_pkg::PH_END;
            end
            fcp_pkg::PH_END:
            begin
                rx_phase = fcp_pkg::PH_HUNT;
                if (b != cur_end)
                    pending_results.push_back(make_result(fcp_pkg::ST_END_BYTE, frame_len,
                        1'b0, 8'd0, 5'd0, 1'b1));
                else if (frame_len == 0)
                    pending_results.push_back(make_result(fcp_pkg::ST_OK, 6'd0,
                        1'b0, 8'd0, 5'd0, 1'b1));
                else
                    for (int i = 0; i < frame_len; i++)
                        pending_results.push_back(make_result(fcp_pkg::ST_OK, frame_len,
                            1'b1, frame_buf[i], i[4:0], (i + 1 == frame_len)));
            end
            default:
                rx_phase = fcp_pkg::PH_HUNT;
        endcase
    endtask

    // Offer one byte, wait for it to be taken, then idle a while
    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_ch.valid   <= 1'b1;
        rx_ch.payload <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        parse_byte(b);
        bytes_sent++;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Whole frame built from the current delimiters; lengths above the buffer stop early
    task automatic send_frame(input logic [7:0] cmd, input int len, input frame_flaw_t flaw,
                              input bit delim_payload);
        logic [7:0] sum;
        logic [7:0] b;
        frames_sent++;
        send_byte(cur_start);
        send_byte(cmd);
        send_byte(len[7:0]);
        if (len > PAYLOAD_MAX)
            return;
        sum = cur_start ^ cmd ^ len[7:0];
        for (int i = 0; i < len; i++)
        begin
            if (delim_payload)
                b = i[0] ? cur_end : cur_start;
            else if ($urandom_range(0, 7) == 0)
                b = $urandom_range(0, 1) ? cur_end : cur_start;
            else
                b = 8'($urandom_range(0, 255));
            sum = sum ^ b;
            send_byte(b);
        end
        if (flaw == FLAW_CHECKSUM)
            sum = sum ^ (8'd1 << $urandom_range(0, 7));
        send_byte(sum);
        if (flaw == FLAW_END_BYTE)
            send_byte(cur_end ^ 8'($urandom_range(1, 255)));
        else
            send_byte(cur_end);
    endtask

    // Stop offering, wait for every expected word, then let the block settle
    task automatic drain();
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input fcp_pkg::cfg_reg_t idx, input logic [7:0] v);
        fcp_pkg::cfg_word_t w;
        w.index = idx;
        w.data  = v;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= w;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            fcp_pkg::CFG_START_BYTE: cur_start = v;
            fcp_pkg::CFG_END_BYTE:   cur_end   = v;
            default:        ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result sink: random gaps, plus a long hold-off on request
    initial
    begin
        int gap;
        int hold_left;
        gap       = 0;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (backpressure_req)
            begin
                hold_left        = HOLD_CYCLES;
                backpressure_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                gap--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (!rx_steady)
                    gap = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each taken result word with the oldest expected one
    always @(posedge clk)
    begin : result_check
        fcp_pkg::result_t got;
        fcp_pkg::result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.payload;
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected: status %0d command %0d",
                       got.status, got.command);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("command", want.command, got.command);
                check_field("length", want.length, got.length);
                check_field("has_payload", want.has_payload, got.has_payload);
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("byte_index", want.byte_index, got.byte_index);
                check_field("last", want.last, got.last);
                results_checked++;
            end
        end
    end

    // Directed tests
    task automatic test_empty_frame();
        send_frame(8'hFF, 0, FLAW_NONE, 1'b0);
        drain();
    endtask

    task automatic test_length_too_large();
        // one just over the buffer, one that saturates the length field
        send_byte(cur_start);
        send_byte(8'h00);
        send_byte(8'd33);
        send_byte(cur_start);
        send_byte(8'hA5);
        send_byte(8'hFF);
        drain();
    endtask

    task automatic test_checksum_error();
        send_frame(8'h5C, 1, FLAW_CHECKSUM, 1'b0);
        drain();
    endtask

    task automatic test_bad_end_byte();
        send_frame(8'h80, 0, FLAW_END_BYTE, 1'b0);
        drain();
    endtask

    task automatic test_delimiters_in_payload();
        send_frame(8'h01, 2, FLAW_NONE, 1'b1);
        drain();
    endtask

    task automatic test_config_mid_frame();
        logic [7:0] sum;
        write_reg(fcp_pkg::CFG_START_BYTE, 8'h10);
        write_reg(fcp_pkg::CFG_END_BYTE, 8'h20);
        send_byte(8'h10);
        send_byte(8'h33);
        drain();
        // new start byte must be the one folded into the checksum
        write_reg(fcp_pkg::CFG_START_BYTE, 8'h11);
        send_byte(8'd1);
        send_byte(8'h00);
        sum = cur_start ^ 8'h33 ^ 8'd1 ^ 8'h00;
        send_byte(sum);
        drain();
        write_reg(fcp_pkg::CFG_END_BYTE, 8'h21);
        send_byte(8'h21);
        drain();
    endtask

    task automatic test_output_backpressure();
        tx_steady        = 1'b1;
        backpressure_req = 1'b1;
        for (int i = 0; i < 4; i++)
            send_frame(8'($urandom_range(0, 255)), 8, FLAW_NONE, 1'b0);
        drain();
        tx_steady = 1'b0;
    endtask

    // Random traffic under several delimiter settings
    task automatic test_random_traffic();
        logic [7:0] seg_start [5];
        logic [7:0] seg_end   [5];
        int seg_limit;
        int r;
        int len;
        seg_start = '{8'h02, 8'h00, 8'hFF, 8'h5A, 8'h00};
        seg_end   = '{8'h03, 8'hFF, 8'h00, 8'h5A, 8'h00};
        seg_start[4] = 8'($urandom_range(0, 255));
        seg_end[4]   = 8'($urandom_range(0, 255));
        for (int seg = 0; seg < 5; seg++)
        begin
            drain();
            write_reg(fcp_pkg::CFG_START_BYTE, seg_start[seg]);
            write_reg(fcp_pkg::CFG_END_BYTE, seg_end[seg]);
            tx_steady = ($urandom_range(0, 2) == 0);
            rx_steady = ($urandom_range(0, 2) == 0);
            seg_limit = bytes_sent + RANDOM_BYTES / 5;
            if (seg == 1 || seg == 3)
                send_frame(8'($urandom_range(0, 255)), PAYLOAD_MAX, FLAW_NONE, 1'b0);
            while (bytes_sent < seg_limit)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_byte(8'($urandom_range(0, 255)));
                else if (r < 14)
                    send_frame(8'($urandom_range(0, 255)), $urandom_range(33, 255),
                               FLAW_NONE, 1'b0);
                else if (r < 20)
                    send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 6),
                               FLAW_CHECKSUM, 1'b0);
                else if (r < 26)
                    send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 6),
                               FLAW_END_BYTE, 1'b0);
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 85)
                        len = $urandom_range(0, 6);
                    else if (r < 95)
                        len = $urandom_range(7, 16);
                    else
                        len = $urandom_range(17, PAYLOAD_MAX);
                    send_frame(8'($urandom_range(0, 255)), len, FLAW_NONE, 1'b0);
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain();
    endtask

    // Main sequence
    initial
    begin
        rst_n            <= 1'b0;
        rx_ch.valid      <= 1'b0;
        rx_ch.payload    <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.payload   <= '0;
        cur_start        = fcp_pkg::START_BYTE_RST;
        cur_end          = fcp_pkg::END_BYTE_RST;
        rx_phase         = fcp_pkg::PH_HUNT;
        frame_cmd        = '0;
        frame_len        = '0;
        fill_count       = 0;
        frame_xor        = '0;
        bytes_sent       = 0;
        frames_sent      = 0;
        results_checked  = 0;
        mismatch_count   = 0;
        cycle_count      = 0;
        tx_steady        = 1'b0;
        rx_steady        = 1'b0;
        backpressure_req = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_frame();
        test_length_too_large();
        test_checksum_error();
        test_bad_end_byte();
        test_delimiters_in_payload();
        test_config_mid_frame();
        test_output_backpressure();
        test_random_traffic();

        $display("Covered %0d bytes in %0d frames, %0d result words compared,",
                 bytes_sent, frames_sent, results_checked);
        $display("across five delimiter settings and a long output hold-off.");
        if (mismatch_count == 0)
            $display("framed_command_parser: match");
        else
            $display("framed_command_parser: mismatch");
        $finish;
    end

endmodule

FILE: files.f
rtl/fcp_pkg.sv
rtl/fcp_stream_if.sv
rtl/fcp_ram.sv
rtl/fcp_ctrl.sv
rtl/fcp_datapath.sv
rtl/framed_command_parser.sv
tb/testbench.sv
